// ===== src/rrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rrf_pkg: shared types, constants and the sine table
// Request and result payloads, coordinate types and the status structs that
// pass between the rotated rectangle fill modules.
// ----------------------------------------------------------------------------
package rrf_pkg;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam int COORD_W = 14;
    localparam int PIX_W   = 12;
    localparam int ADDR_W  = 20;

    // signed pixel coordinate of the scan and the bounding box
    typedef logic signed [COORD_W-1:0] t_coord;

    typedef logic signed [15:0] t_q15;

    // one load or tick request
    typedef struct packed {
        logic              action;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [11:0]       rect_width;
        logic [11:0]       rect_height;
        logic [8:0]        angle_degrees;
        logic [7:0]        red_in;
        logic [7:0]        green_in;
        logic [7:0]        blue_in;
        logic [7:0]        alpha_in;
    } t_req;

    // one visited pixel
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] pixel_address;
        logic [7:0]        red_out;
        logic [7:0]        green_out;
        logic [7:0]        blue_out;
        logic [7:0]        alpha_out;
        logic              last_of_scan;
    } t_res;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_color;

    // rectangle held for the whole scan
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [11:0]        hw;
        logic [11:0]        hh;
        t_q15               sin;
        t_q15               cos;
        t_color             color;
    } t_rect;

    typedef struct packed {
        t_coord min_x;
        t_coord max_x;
        t_coord min_y;
        t_coord max_y;
    } t_box;

    typedef struct packed {
        logic busy;
        logic box_done;
    } t_setup_status;

    typedef struct packed {
        logic   busy;
        logic   last;
        t_coord x;
        t_coord y;
    } t_scan_pos;

    typedef enum logic [1:0] {
        LD_IDLE,
        LD_TABLE,
        LD_MULT,
        LD_BOX
    } t_load_state;

    // first quadrant of round(32768*sin(d)), saturated at one
    localparam t_q15 QUARTER_SINE [91] = '{
        16'sd0, 16'sd572, 16'sd1144, 16'sd1715, 16'sd2286, 16'sd2856, 16'sd3425,
        16'sd3993, 16'sd4560, 16'sd5126, 16'sd5690, 16'sd6252, 16'sd6813,
        16'sd7371, 16'sd7927, 16'sd8481, 16'sd9032, 16'sd9580, 16'sd10126,
        16'sd10668, 16'sd11207, 16'sd11743, 16'sd12275, 16'sd12803, 16'sd13328,
        16'sd13848, 16'sd14365, 16'sd14876, 16'sd15384, 16'sd15886, 16'sd16384,
        16'sd16877, 16'sd17364, 16'sd17847, 16'sd18324, 16'sd18795, 16'sd19261,
        16'sd19720, 16'sd20174, 16'sd20622, 16'sd21063, 16'sd21498, 16'sd21926,
        16'sd22348, 16'sd22763, 16'sd23170, 16'sd23571, 16'sd23965, 16'sd24351,
        16'sd24730, 16'sd25102, 16'sd25466, 16'sd25822, 16'sd26170, 16'sd26510,
        16'sd26842, 16'sd27166, 16'sd27482, 16'sd27789, 16'sd28088, 16'sd28378,
        16'sd28660, 16'sd28932, 16'sd29197, 16'sd29452, 16'sd29698, 16'sd29935,
        16'sd30163, 16'sd30382, 16'sd30592, 16'sd30792, 16'sd30983, 16'sd31164,
        16'sd31336, 16'sd31499, 16'sd31651, 16'sd31795, 16'sd31928, 16'sd32052,
        16'sd32166, 16'sd32270, 16'sd32365, 16'sd32449, 16'sd32524, 16'sd32588,
        16'sd32643, 16'sd32688, 16'sd32723, 16'sd32748, 16'sd32763, 16'sd32767
    };

    // sine of a whole-degree angle in 0..359, folded onto the first quadrant
    function automatic t_q15 sine_q15(input logic [8:0] deg);
        logic [8:0] idx;
        logic       neg;
        t_q15       val;
        if (deg <= 9'd90) begin
            idx = deg;
            neg = 1'b0;
        end else if (deg <= 9'd180) begin
            idx = 9'd180 - deg;
            neg = 1'b0;
        end else if (deg <= 9'd270) begin
            idx = deg - 9'd180;
            neg = 1'b1;
        end else begin
            idx = 9'd360 - deg;
            neg = 1'b1;
        end
        val = QUARTER_SINE[idx[6:0]];
        return neg ? -val : val;
    endfunction

endpackage

// ===== src/rrf_req_if.sv =====
// ----------------------------------------------------------------------------
// rrf_req_if: request channel
// Valid/ready channel that carries load and tick requests.
// ----------------------------------------------------------------------------
interface rrf_req_if;
    logic          valid;
    logic          ready;
    rrf_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/rrf_res_if.sv =====
// ----------------------------------------------------------------------------
// rrf_res_if: result channel
// Valid/ready channel that carries the visited pixel results.
// ----------------------------------------------------------------------------
interface rrf_res_if;
    logic          valid;
    logic          ready;
    rrf_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/rrf_setup.sv =====
// ----------------------------------------------------------------------------
// rrf_setup: rectangle setup sequencer
// Latches a load request, looks up sine and cosine, forms the rotated extents
// and hands the floored and ceiled bounding box to the scanner.
// ----------------------------------------------------------------------------
module rrf_setup (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  rrf_pkg::t_req          i_data,
    output rrf_pkg::t_setup_status o_status,
    output rrf_pkg::t_box          o_box,
    output rrf_pkg::t_rect         o_rect
);

    rrf_pkg::t_load_state r_state, n_state;

    logic signed [15:0] r_cx, r_cy;
    logic [11:0]        r_hw, r_hh;
    logic [8:0]         r_ang;
    rrf_pkg::t_color    r_color;
    rrf_pkg::t_q15      r_sin, r_cos;
    logic signed [28:0] r_wc, r_hs, r_ws, r_hc;

    logic [8:0]         ang_mod;
    logic [9:0]         cos_sum;
    logic [8:0]         cos_ang;
    logic signed [30:0] cxs, cys, ext_x, ext_y;
    logic signed [30:0] min_x, max_x, min_y, max_y;

    function automatic logic signed [29:0] abs_prod(input logic signed [28:0] a);
        logic signed [29:0] e;
        e = 30'(a);
        return a[28] ? -e : e;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrf_pkg::LD_IDLE:  if (i_load) n_state = rrf_pkg::LD_TABLE;
            rrf_pkg::LD_TABLE: n_state = rrf_pkg::LD_MULT;
            rrf_pkg::LD_MULT:  n_state = rrf_pkg::LD_BOX;
            rrf_pkg::LD_BOX:   n_state = rrf_pkg::LD_IDLE;
            default:           n_state = rrf_pkg::LD_IDLE;
        endcase
    end

    // status outputs
    always_comb begin
        o_status = '0;
        unique case (r_state)
            rrf_pkg::LD_IDLE:  o_status = '0;
            rrf_pkg::LD_TABLE: o_status.busy = 1'b1;
            rrf_pkg::LD_MULT:  o_status.busy = 1'b1;
            rrf_pkg::LD_BOX: begin
                o_status.busy     = 1'b1;
                o_status.box_done = 1'b1;
            end
            default:           o_status = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrf_pkg::LD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // angle folded into 0..359, cosine angle a quarter turn on
    assign ang_mod = (i_data.angle_degrees >= 9'd360) ? i_data.angle_degrees - 9'd360
                                                      : i_data.angle_degrees;
    assign cos_sum = {1'b0, r_ang} + 10'd90;
    assign cos_ang = (cos_sum >= 10'd360) ? 9'(cos_sum - 10'd360) : cos_sum[8:0];

    // held rectangle and intermediate products
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cx    <= i_data.center_x;
            r_cy    <= i_data.center_y;
            r_hw    <= i_data.rect_width;
            r_hh    <= i_data.rect_height;
            r_ang   <= ang_mod;
            r_color <= '{red: i_data.red_in, green: i_data.green_in,
                         blue: i_data.blue_in, alpha: i_data.alpha_in};
        end
        if (r_state == rrf_pkg::LD_TABLE) begin
            r_sin <= rrf_pkg::sine_q15(r_ang);
            r_cos <= rrf_pkg::sine_q15(cos_ang);
        end
        if (r_state == rrf_pkg::LD_MULT) begin
            r_wc <= 29'($signed({1'b0, r_hw})) * 29'(r_cos);
            r_hs <= 29'($signed({1'b0, r_hh})) * 29'(r_sin);
            r_ws <= 29'($signed({1'b0, r_hw})) * 29'(r_sin);
            r_hc <= 29'($signed({1'b0, r_hh})) * 29'(r_cos);
        end
    end

    // corner extents in 2^-16 pixel, all four sign pairs give min and max
    assign cxs   = $signed({{3{r_cx[15]}}, r_cx, 12'd0});
    assign cys   = $signed({{3{r_cy[15]}}, r_cy, 12'd0});
    assign ext_x = 31'(abs_prod(r_wc)) + 31'(abs_prod(r_hs));
    assign ext_y = 31'(abs_prod(r_ws)) + 31'(abs_prod(r_hc));
    assign min_x = cxs - ext_x;
    assign max_x = cxs + ext_x;
    assign min_y = cys - ext_y;
    assign max_y = cys + ext_y;

    // floor of the low ends, ceiling of the high ends
    assign o_box.min_x = rrf_pkg::t_coord'(min_x >>> 16);
    assign o_box.min_y = rrf_pkg::t_coord'(min_y >>> 16);
    assign o_box.max_x = rrf_pkg::t_coord'((max_x + 31'sd65535) >>> 16);
    assign o_box.max_y = rrf_pkg::t_coord'((max_y + 31'sd65535) >>> 16);

    assign o_rect = '{cx: r_cx, cy: r_cy, hw: r_hw, hh: r_hh,
                      sin: r_sin, cos: r_cos, color: r_color};

endmodule

// ===== src/rrf_scan.sv =====
// ----------------------------------------------------------------------------
// rrf_scan: bounding box scanner
// Holds the scan position and walks the box column by column, one pixel per
// accepted tick.
// ----------------------------------------------------------------------------
module rrf_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_box_done,
    input  rrf_pkg::t_box      i_box,
    input  logic               i_step,
    output rrf_pkg::t_scan_pos o_pos
);

    logic            r_busy;
    rrf_pkg::t_coord r_x, r_y, r_min_y, r_max_x, r_max_y;
    logic            last;

    assign last = (r_x >= r_max_x) && (r_y >= r_max_y);

    // scan position, column-major
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
        end else if (i_box_done) begin
            r_busy  <= 1'b1;
            r_x     <= i_box.min_x;
            r_y     <= i_box.min_y;
            r_min_y <= i_box.min_y;
            r_max_x <= i_box.max_x;
            r_max_y <= i_box.max_y;
        end else if (i_load) begin
            r_busy <= 1'b0;
        end else if (i_step && r_busy) begin
            if (last) begin
                r_busy <= 1'b0;
            end else if (r_y >= r_max_y) begin
                r_y <= r_min_y;
                r_x <= r_x + rrf_pkg::t_coord'(1);
            end else begin
                r_y <= r_y + rrf_pkg::t_coord'(1);
            end
        end
    end

    assign o_pos = '{busy: r_busy, last: last, x: r_x, y: r_y};

endmodule

// ===== src/rrf_pixel_pipe.sv =====
// ----------------------------------------------------------------------------
// rrf_pixel_pipe: pixel test pipeline
// Three stages: centre offsets, rotation products and address, then the
// inside test into the result register. Each stage stalls only when full.
// ----------------------------------------------------------------------------
module rrf_pixel_pipe #(
    parameter int SCREEN_W = 1024,
    parameter int SCREEN_H = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rrf_pkg::t_scan_pos i_pos,
    input  rrf_pkg::t_rect     i_rect,
    output logic               o_take,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output rrf_pkg::t_res      o_out_data
);

    localparam rrf_pkg::t_coord SCR_W = rrf_pkg::t_coord'(SCREEN_W);
    localparam rrf_pkg::t_coord SCR_H = rrf_pkg::t_coord'(SCREEN_H);
    localparam logic [12:0]     SW    = 13'(SCREEN_W);

    typedef struct packed {
        logic signed [18:0]          x_off;
        logic signed [18:0]          y_off;
        rrf_pkg::t_q15               sin;
        rrf_pkg::t_q15               cos;
        logic [11:0]                 hw;
        logic [11:0]                 hh;
        rrf_pkg::t_color             color;
        logic [rrf_pkg::PIX_W-1:0]   px;
        logic [rrf_pkg::PIX_W-1:0]   py;
        logic                        on_screen;
        logic                        last;
    } t_stage1;

    typedef struct packed {
        logic signed [34:0]          xc;
        logic signed [34:0]          ys;
        logic signed [34:0]          yc;
        logic signed [34:0]          xs;
        logic [11:0]                 hw;
        logic [11:0]                 hh;
        rrf_pkg::t_color             color;
        logic [rrf_pkg::ADDR_W-1:0]  addr;
        logic                        on_screen;
        logic                        last;
    } t_stage2;

    logic          r_v1, r_v2, r_v3;
    t_stage1       r_s1, n_s1;
    t_stage2       r_s2;
    rrf_pkg::t_res r_out, n_out;

    logic take1, take2, take3;

    logic [24:0]        addr_full;
    logic signed [35:0] u, v, lw, lh;
    logic               in_rect;

    // stage moves when the one after it is empty or moving
    assign take3  = !r_v3 || i_out_ready;
    assign take2  = !r_v2 || take3;
    assign take1  = !r_v1 || take2;
    assign o_take = take1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (take1) r_v1 <= i_push;
            if (take2) r_v2 <= r_v1;
            if (take3) r_v3 <= r_v2;
        end
    end

    // stage 1: offsets from the centre in Q15.4, screen test
    always_comb begin
        n_s1.x_off     = (19'(i_pos.x) <<< 4) - 19'(i_rect.cx);
        n_s1.y_off     = (19'(i_pos.y) <<< 4) - 19'(i_rect.cy);
        n_s1.sin       = i_rect.sin;
        n_s1.cos       = i_rect.cos;
        n_s1.hw        = i_rect.hw;
        n_s1.hh        = i_rect.hh;
        n_s1.color     = i_rect.color;
        n_s1.px        = i_pos.x[rrf_pkg::PIX_W-1:0];
        n_s1.py        = i_pos.y[rrf_pkg::PIX_W-1:0];
        n_s1.on_screen = !i_pos.x[rrf_pkg::COORD_W-1] && !i_pos.y[rrf_pkg::COORD_W-1] &&
                         (i_pos.x < SCR_W) && (i_pos.y < SCR_H);
        n_s1.last      = i_pos.last;
    end

    // stage 2: rotation products and frame address
    assign addr_full = 25'(r_s1.py) * 25'(SW) + 25'(r_s1.px);

    // stage 3: back-rotated offset against the half sizes
    assign u       = 36'(r_s2.xc) + 36'(r_s2.ys);
    assign v       = 36'(r_s2.yc) - 36'(r_s2.xs);
    assign lw      = $signed(36'({r_s2.hw, 18'd0}));
    assign lh      = $signed(36'({r_s2.hh, 18'd0}));
    assign in_rect = r_s2.on_screen && (u >= -lw) && (u <= lw) && (v >= -lh) && (v <= lh);

    always_comb begin
        n_out              = '0;
        n_out.write_enable = in_rect;
        n_out.last_of_scan = r_s2.last;
        if (in_rect) begin
            n_out.pixel_address = r_s2.addr;
            n_out.red_out       = r_s2.color.red;
            n_out.green_out     = r_s2.color.green;
            n_out.blue_out      = r_s2.color.blue;
            n_out.alpha_out     = r_s2.color.alpha;
        end
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        if (take1) r_s1 <= n_s1;
        if (take2) begin
            r_s2.xc        <= 35'(r_s1.x_off) * 35'(r_s1.cos);
            r_s2.ys        <= 35'(r_s1.y_off) * 35'(r_s1.sin);
            r_s2.yc        <= 35'(r_s1.y_off) * 35'(r_s1.cos);
            r_s2.xs        <= 35'(r_s1.x_off) * 35'(r_s1.sin);
            r_s2.hw        <= r_s1.hw;
            r_s2.hh        <= r_s1.hh;
            r_s2.color     <= r_s1.color;
            r_s2.addr      <= addr_full[rrf_pkg::ADDR_W-1:0];
            r_s2.on_screen <= r_s1.on_screen;
            r_s2.last      <= r_s1.last;
        end
        if (take3) r_out <= n_out;
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

endmodule

// ===== src/rotated_rectangle_fill_unit.sv =====
// ----------------------------------------------------------------------------
// rotated_rectangle_fill_unit: rotated rectangle rasterizer
// A load request sets up a rotated rectangle and its bounding box; each tick
// request then visits one box pixel and yields one pixel write result.
//
// i_req carries load and tick requests, o_res one result per tick while a
// scan runs. Ticks with no scan running, and loads, give no result.
// A load runs through the request cycle, the sine/cosine table lookup, the
// width/height products and the box corners; i_req.ready is low for the
// last three. A new load drops a running scan.
// Ticks are taken one per cycle unless setup is busy or the pipeline is full;
// each passes the offset, multiplier and inside-test stages into the result
// register. The last pixel of the box has last_of_scan set.
// When the receiver stalls, the three stages fill in turn and i_req.ready
// falls only once all of them hold a pixel.
// After reset no scan runs and the pipeline is empty.
// ----------------------------------------------------------------------------
module rotated_rectangle_fill_unit #(
    parameter int SCREEN_W = 1024,
    parameter int SCREEN_H = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rrf_req_if.sink  i_req,
    rrf_res_if.source o_res
);

    rrf_pkg::t_setup_status status;
    rrf_pkg::t_box          box;
    rrf_pkg::t_rect         rect;
    rrf_pkg::t_scan_pos     pos;

    logic req_fire, load_fire, tick_fire, pipe_take;

    // request decode
    assign req_fire    = i_req.valid && i_req.ready;
    assign load_fire   = req_fire && (i_req.data.action == rrf_pkg::ACT_LOAD);
    assign tick_fire   = req_fire && (i_req.data.action == rrf_pkg::ACT_TICK);
    assign i_req.ready = pipe_take && !status.busy;

    // rectangle setup
    rrf_setup u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load_fire),
        .i_data   (i_req.data),
        .o_status (status),
        .o_box    (box),
        .o_rect   (rect)
    );

    // box scanner
    rrf_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load_fire),
        .i_box_done (status.box_done),
        .i_box      (box),
        .i_step     (tick_fire),
        .o_pos      (pos)
    );

    // pixel test pipeline
    rrf_pixel_pipe #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (tick_fire && pos.busy),
        .i_pos       (pos),
        .i_rect      (rect),
        .o_take      (pipe_take),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_data  (o_res.data)
    );

    // no request is taken while the setup runs
    a_load_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_fire |=> !i_req.ready ##1 !i_req.ready ##1 !i_req.ready)
        else $error("request taken during rectangle setup");

    // finished setup starts a scan
    a_box_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.box_done |=> pos.busy)
        else $error("scan not started after setup");

    // the last pixel of the box ends the scan
    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_fire && pos.busy && pos.last) |=> !pos.busy)
        else $error("scan still running after last pixel");

endmodule
